FILE: src/external_interrupt_edge_detector_defines.svh
// Assertion macros for the external interrupt block.
`ifndef EXTERNAL_INTERRUPT_EDGE_DETECTOR_DEFINES_SVH
`define EXTERNAL_INTERRUPT_EDGE_DETECTOR_DEFINES_SVH

`define EIED_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define EIED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/eied_pkg.sv
package eied_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned OffsetW   = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned NumPins   = 3;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 16;
  localparam int unsigned CfgW      = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_FALL = 2'd0,
    MODE_RISE = 2'd1,
    MODE_HIGH = 2'd2,
    MODE_LOW  = 2'd3
  } mode_e;

  localparam logic [OffsetW-1:0] OFF_PORT   = 3'd0;
  localparam logic [OffsetW-1:0] OFF_AUX    = 3'd1;
  localparam logic [OffsetW-1:0] OFF_CTRL_A = 3'd2;
  localparam logic [OffsetW-1:0] OFF_CTRL_B = 3'd3;
  localparam logic [OffsetW-1:0] OFF_SELECT = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0]   read_data;
    logic [NumPins-1:0] irq_raise;
  } result_t;

endpackage

FILE: src/external_interrupt_edge_detector.sv
// Results are registered: in the output register, or the skid entry on a stall.
// Throughput: one beat per cycle, accepted while the second buffer entry is empty.
// A two-entry output buffer keeps input accepted while one result waits downstream.
// Reset (rst_ni low, asynchronous): previous pin levels go to all high, all bus
// registers and the trigger modes go to zero, and the output buffer empties.
module external_interrupt_edge_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [eied_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: reg_offset[2:0], write_data[10:3], pin_now[13:11].
  input  logic [eied_pkg::InDataW-1:0]  s_axis_tdata,
  // Fields from bit 0: cmd[1:0].
  input  logic [eied_pkg::CmdW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: read_data[7:0], irq_raise[10:8].
  output logic [eied_pkg::OutDataW-1:0] m_axis_tdata
);
  import eied_pkg::*;

  logic [CfgW-1:0]    trig_modes_q;
  logic [NumPins-1:0] prev_pins_q, prev_pins_d;
  logic [NumPins-1:0] port_latch_q, port_latch_d;
  logic               aux_bit_q, aux_bit_d;
  logic [NumPins-1:0] ctrl_a_q, ctrl_a_d;
  logic [NumPins-1:0] ctrl_b_q, ctrl_b_d;
  logic [NumPins-1:0] in_sel_q, in_sel_d;

  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  result_t            out_q, out_d;
  result_t            skid_q, skid_d;
  result_t            res;

  logic [OffsetW-1:0] offset;
  logic [ByteW-1:0]   wdata;
  logic [NumPins-1:0] pins;
  logic [NumPins-1:0] hit;
  logic               in_fire, out_fire;

  assign offset = s_axis_tdata[OffsetW-1:0];
  assign wdata  = s_axis_tdata[OffsetW+ByteW-1:OffsetW];
  assign pins   = s_axis_tdata[OffsetW+ByteW+NumPins-1:OffsetW+ByteW];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - ByteW - NumPins){1'b0}}, out_q.irq_raise,
                          out_q.read_data};

  always_comb begin
    for (int p = 0; p < NumPins; p++) begin
      case (mode_e'(trig_modes_q[2*(p+1) +: 2]))
        MODE_FALL: hit[p] = prev_pins_q[p] && !pins[p];
        MODE_RISE: hit[p] = !prev_pins_q[p] && pins[p];
        MODE_HIGH: hit[p] = pins[p];
        default:   hit[p] = !pins[p];
      endcase
    end
  end

  always_comb begin
    res          = '0;
    prev_pins_d  = prev_pins_q;
    port_latch_d = port_latch_q;
    aux_bit_d    = aux_bit_q;
    ctrl_a_d     = ctrl_a_q;
    ctrl_b_d     = ctrl_b_q;
    in_sel_d     = in_sel_q;
    case (cmd_e'(s_axis_tuser))
      CMD_READ: begin
        case (offset)
          OFF_PORT: begin
            res.read_data = {{(ByteW-NumPins){1'b0}},
                             (pins & in_sel_q) | (port_latch_q & ~in_sel_q)};
          end
          OFF_AUX:    res.read_data = {{(ByteW-1){1'b0}}, aux_bit_q};
          OFF_CTRL_A: res.read_data = {{(ByteW-NumPins){1'b0}}, ctrl_a_q};
          OFF_CTRL_B: res.read_data = {{(ByteW-NumPins){1'b0}}, ctrl_b_q};
          OFF_SELECT: res.read_data = {{(ByteW-NumPins){1'b0}}, in_sel_q};
          default:    res.read_data = '0;
        endcase
      end
      CMD_WRITE: begin
        case (offset)
          OFF_PORT:   port_latch_d = wdata[NumPins-1:0];
          OFF_AUX:    aux_bit_d    = wdata[0];
          OFF_CTRL_A: ctrl_a_d     = wdata[NumPins-1:0];
          OFF_CTRL_B: ctrl_b_d     = wdata[NumPins-1:0];
          OFF_SELECT: in_sel_d     = wdata[NumPins-1:0];
          default:    ;
        endcase
      end
      CMD_TICK: begin
        res.irq_raise = hit;
        prev_pins_d   = pins;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (in_fire) begin
      if (!out_valid_q || m_axis_tready) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_modes_q <= '0;
      prev_pins_q  <= '1;
      port_latch_q <= '0;
      aux_bit_q    <= 1'b0;
      ctrl_a_q     <= '0;
      ctrl_b_q     <= '0;
      in_sel_q     <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        trig_modes_q <= cfg_data_i;
      end
      if (in_fire) begin
        prev_pins_q  <= prev_pins_d;
        port_latch_q <= port_latch_d;
        aux_bit_q    <= aux_bit_d;
        ctrl_a_q     <= ctrl_a_d;
        ctrl_b_q     <= ctrl_b_d;
        in_sel_q     <= in_sel_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

FILE: src/eied_checker.sv
`include "external_interrupt_edge_detector_defines.svh"

module eied_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [eied_pkg::OutDataW-1:0] m_axis_tdata
);

  // A stalled output beat stays valid and keeps its data.
`EIED_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "out beat dropped")
`EIED_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "out data changed")

  // Input is only held off when a result is waiting on the output.
`EIED_ASSERT_IMPL(a_full_has_out, !s_axis_tready, m_axis_tvalid, "input stalled with empty output")

  // A beat carries either read data or interrupt requests, never both, in 3-bit fields.
`EIED_ASSERT_IMPL(a_out_fields, m_axis_tvalid, (m_axis_tdata[7:3] == 5'd0) && (m_axis_tdata[15:11] == 5'd0) && ((m_axis_tdata[2:0] == 3'd0) || (m_axis_tdata[10:8] == 3'd0)), "bad result fields")

endmodule

bind external_interrupt_edge_detector eied_checker u_eied_checker (.*);

FILE: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eied_pkg::*;

  localparam logic [CmdW-1:0]    CMD_NONE  = 2'd3;
  localparam logic [OffsetW-1:0] OFF_SPARE = 3'd5;
  localparam logic [OffsetW-1:0] OFF_TOP   = 3'd7;

  localparam int unsigned NumPhases      = 6;
  localparam int unsigned RandomPerPhase = 288;
  localparam int unsigned DrainCycles    = 4;
  localparam int unsigned RxHoldCycles   = 60;
  localparam int unsigned QuietLimit     = 2000;
  localparam int unsigned MaxReports     = 20;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [OffsetW-1:0] offset;
    logic [ByteW-1:0]   wdata;
    logic [NumPins-1:0] pins;
    logic               typed;
    logic [ByteW-1:0]   rd;
    logic [NumPins-1:0] irq;
  } row_t;

  // Rows marked typed carry a hand-derived response; the others go to the predictor.
  localparam row_t DirectedRows [26] = '{
    '{CMD_READ,  OFF_PORT,   8'h00, 3'd7, 1'b1, 8'h00, 3'd0},
    '{CMD_READ,  OFF_AUX,    8'hff, 3'd7, 1'b1, 8'h00, 3'd0},
    '{CMD_READ,  OFF_CTRL_A, 8'h00, 3'd0, 1'b1, 8'h00, 3'd0},
    '{CMD_READ,  OFF_CTRL_B, 8'h00, 3'd0, 1'b1, 8'h00, 3'd0},
    '{CMD_READ,  OFF_SELECT, 8'h00, 3'd0, 1'b1, 8'h00, 3'd0},
    '{CMD_READ,  OFF_TOP,    8'h00, 3'd7, 1'b1, 8'h00, 3'd0},
    '{CMD_TICK,  OFF_PORT,   8'h00, 3'd7, 1'b1, 8'h00, 3'd0},
    '{CMD_TICK,  OFF_PORT,   8'hff, 3'd0, 1'b1, 8'h00, 3'd7},
    '{CMD_TICK,  OFF_PORT,   8'h00, 3'd0, 1'b1, 8'h00, 3'd0},
    '{CMD_TICK,  OFF_PORT,   8'h00, 3'd5, 1'b1, 8'h00, 3'd0},
    '{CMD_TICK,  OFF_PORT,   8'h00, 3'd2, 1'b1, 8'h00, 3'd5},
    '{CMD_WRITE, OFF_PORT,   8'hff, 3'd0, 1'b1, 8'h00, 3'd0},
    '{CMD_READ,  OFF_PORT,   8'h00, 3'd0, 1'b1, 8'h07, 3'd0},
    '{CMD_WRITE, OFF_AUX,    8'hff, 3'd0, 1'b1, 8'h00, 3'd0},
    '{CMD_READ,  OFF_AUX,    8'h00, 3'd0, 1'b1, 8'h01, 3'd0},
    '{CMD_WRITE, OFF_CTRL_A, 8'hfe, 3'd0, 1'b1, 8'h00, 3'd0},
    '{CMD_READ,  OFF_CTRL_A, 8'h00, 3'd0, 1'b1, 8'h06, 3'd0},
    '{CMD_WRITE, OFF_CTRL_B, 8'h0d, 3'd7, 1'b1, 8'h00, 3'd0},
    '{CMD_READ,  OFF_CTRL_B, 8'h00, 3'd7, 1'b1, 8'h05, 3'd0},
    '{CMD_WRITE, OFF_SELECT, 8'hff, 3'd0, 1'b1, 8'h00, 3'd0},
    '{CMD_READ,  OFF_PORT,   8'h00, 3'd2, 1'b1, 8'h02, 3'd0},
    '{CMD_WRITE, OFF_SELECT, 8'h05, 3'd0, 1'b0, 8'h00, 3'd0},
    '{CMD_READ,  OFF_PORT,   8'h00, 3'd2, 1'b0, 8'h00, 3'd0},
    '{CMD_WRITE, OFF_SPARE,  8'hff, 3'd7, 1'b1, 8'h00, 3'd0},
    '{CMD_READ,  OFF_SPARE,  8'h00, 3'd7, 1'b1, 8'h00, 3'd0},
    '{CMD_NONE,  OFF_TOP,    8'hff, 3'd7, 1'b1, 8'h00, 3'd0}
  };

  localparam logic [CfgW-1:0] PhaseModes [4] = '{
    {4{MODE_FALL}},
    {4{MODE_LOW}},
    {MODE_LOW, MODE_HIGH, MODE_RISE, MODE_FALL},
    {MODE_FALL, MODE_RISE, MODE_HIGH, MODE_LOW}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [CmdW-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  logic               beat_typed = 1'b0;
  logic [ByteW-1:0]   beat_rd    = '0;
  logic [NumPins-1:0] beat_irq   = '0;

  logic [CfgW-1:0]    modes       = '0;
  logic [NumPins-1:0] last_pins   = '1;
  logic [NumPins-1:0] latch_bits  = '0;
  logic               aux_flag    = 1'b0;
  logic [NumPins-1:0] ctrl_a_bits = '0;
  logic [NumPins-1:0] ctrl_b_bits = '0;
  logic [NumPins-1:0] select_bits = '0;

  result_t     pending_responses[$];
  int unsigned mismatches       = 0;
  int unsigned quiet_cycles     = 0;
  int unsigned sender_idle_pct  = 38;
  int unsigned recv_idle_pct    = 48;
  int unsigned hold_requests    = 0;
  int unsigned settings_written = 0;
  int unsigned irq_ticks        = 0;
  int unsigned cmd_count [4]    = '{0, 0, 0, 0};

  external_interrupt_edge_detector u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic result_t access_response(input logic [CmdW-1:0] cmd,
                                              input logic [OffsetW-1:0] off,
                                              input logic [ByteW-1:0] data,
                                              input logic [NumPins-1:0] pins);
    result_t r;
    mode_e   m;
    logic    hit;
    int      p;
    r = '0;
    case (cmd)
      CMD_READ: begin
        case (off)
          OFF_PORT:   r.read_data = ByteW'((pins & select_bits) | (latch_bits & ~select_bits));
          OFF_AUX:    r.read_data = ByteW'(aux_flag);
          OFF_CTRL_A: r.read_data = ByteW'(ctrl_a_bits);
          OFF_CTRL_B: r.read_data = ByteW'(ctrl_b_bits);
          OFF_SELECT: r.read_data = ByteW'(select_bits);
          default:    r.read_data = '0;
        endcase
      end
      CMD_WRITE: begin
        case (off)
          OFF_PORT:   latch_bits = data[NumPins-1:0];
          OFF_AUX:    aux_flag = data[0];
          OFF_CTRL_A: ctrl_a_bits = data[NumPins-1:0];
          OFF_CTRL_B: ctrl_b_bits = data[NumPins-1:0];
          OFF_SELECT: select_bits = data[NumPins-1:0];
          default: ;
        endcase
      end
      CMD_TICK: begin
        for (p = 0; p < NumPins; p++) begin
          m = mode_e'(modes[2*p+2 +: 2]);
          case (m)
            MODE_FALL: hit = last_pins[p] & ~pins[p];
            MODE_RISE: hit = ~last_pins[p] & pins[p];
            MODE_HIGH: hit = pins[p];
            default:   hit = ~pins[p];
          endcase
          r.irq_raise[p] = hit;
        end
        last_pins = pins;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MaxReports) begin
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin : scoreboard
    result_t want;
    logic    moved;
    moved = 1'b0;
    if (cfg_valid_i && cfg_ready_o) begin
      modes = cfg_data_i;
      settings_written++;
      moved = 1'b1;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      want = access_response(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[10:3],
                             s_axis_tdata[13:11]);
      if (beat_typed) begin
        want.read_data = beat_rd;
        want.irq_raise = beat_irq;
      end
      pending_responses.push_back(want);
      cmd_count[s_axis_tuser]++;
      moved = 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("result beat with nothing pending", m_axis_tdata, 0);
      end else begin
        want = pending_responses.pop_front();
        if (m_axis_tdata[7:0] !== want.read_data) begin
          report_mismatch("read_data", m_axis_tdata[7:0], want.read_data);
        end
        if (m_axis_tdata[10:8] !== want.irq_raise) begin
          report_mismatch("irq_raise", m_axis_tdata[10:8], want.irq_raise);
        end
      end
      if (m_axis_tdata[10:8] != 0) begin
        irq_ticks++;
      end
      moved = 1'b1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin : receiver
    int unsigned holds_served;
    int unsigned hold_left;
    holds_served = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_served < hold_requests) begin
        hold_left = RxHoldCycles;
        holds_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("external_interrupt_edge_detector regression: fail");
    $finish;
  end

  task automatic offer(input row_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({r.pins, r.wdata, r.offset});
    s_axis_tuser  <= r.cmd;
    beat_typed    <= r.typed;
    beat_rd       <= r.rd;
    beat_irq      <= r.irq;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_for_drain();
    @(posedge clk_i);
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    row_t        r;
    int unsigned ph;
    int unsigned k;
    int unsigned sel;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (k = 0; k < $size(DirectedRows); k++) begin
      offer(DirectedRows[k]);
    end
    for (ph = 0; ph < NumPhases; ph++) begin
      s_axis_tvalid <= 1'b0;
      wait_for_drain();
      case (ph / 2)
        0: begin
          sender_idle_pct = 38;
          recv_idle_pct = 48;
        end
        1: begin
          sender_idle_pct = 48;
          recv_idle_pct = 38;
        end
        default: begin
          sender_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      cfg_data_i  <= (ph < 4) ? PhaseModes[ph] : CfgW'($urandom_range(255));
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_valid_i <= 1'b0;
      if (ph >= 4) begin
        hold_requests++;
      end
      for (k = 0; k < RandomPerPhase; k++) begin
        sel = $urandom_range(99);
        r.cmd = (sel < 35) ? CMD_READ : (sel < 65) ? CMD_WRITE :
                (sel < 95) ? CMD_TICK : CMD_NONE;
        r.offset = ($urandom_range(9) == 0) ? OffsetW'($urandom_range(7, 5))
                                            : OffsetW'($urandom_range(4));
        r.wdata = ByteW'($urandom_range(255));
        r.pins  = NumPins'($urandom_range(7));
        r.typed = 1'b0;
        r.rd    = '0;
        r.irq   = '0;
        offer(r);
      end
    end
    s_axis_tvalid <= 1'b0;
    wait_for_drain();
    $display("Run covered %0d reads, %0d writes, %0d ticks and %0d unused commands.",
             cmd_count[CMD_READ], cmd_count[CMD_WRITE], cmd_count[CMD_TICK],
             cmd_count[CMD_NONE]);
    $display("Trigger modes were set %0d times; %0d ticks raised at least one request.",
             settings_written, irq_ticks);
    if (mismatches == 0) begin
      $display("external_interrupt_edge_detector regression: pass");
    end else begin
      $display("external_interrupt_edge_detector regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/eied_pkg.sv
src/external_interrupt_edge_detector.sv
src/eied_checker.sv
sim/tb.sv
